FILE: hdl/cbcu_pkg.sv
// Shared types and constants for the CRC and byte checksum unit.
// No dependencies; every other file imports this package.
package cbcu_pkg;

    localparam int MAX_DEGREE    = 32;
    localparam int DEG_W         = 6;
    localparam int DEG_IDX_W     = $clog2(MAX_DEGREE);
    localparam int CHECKSUM_BITS = 8;
    localparam int HB_COUNT_W    = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GENERATOR_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_DEGREE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 2'd2;

    // Operating modes
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    typedef struct packed {
        logic [MAX_DEGREE-1:0] generator_low;
        logic [DEG_W-1:0]      crc_degree;
        logic                  mode;
    } t_cfg;

    typedef struct packed {
        logic bit_in;
        logic last;
    } t_item;

    typedef struct packed {
        logic [MAX_DEGREE-1:0]    crc_remainder;
        logic [CHECKSUM_BITS-1:0] checksum_byte;
        logic                     crc_error;
        logic                     checksum_error;
    } t_result;

endpackage

FILE: hdl/crc_and_byte_checksum_unit.sv
// Top level of the serial CRC and ones' complement byte checksum unit.
// Depends on cbcu_pkg, cbcu_in_stage and cbcu_core.
//
// The unit takes a message one bit per item, most significant bit first, and
// gives one result on the item marked last, none on the others. In generate
// mode the result carries the CRC remainder of message * x^degree and the
// ones' complement of the end-around-carry byte sum of the message. In check
// mode the whole codeword is divided (crc_error flags a nonzero remainder),
// the final 8 bits are held back as the received checksum and compared with
// the checksum of the bits before them. Throughput is one item per cycle
// unless a last item is held at the output: an item is registered in the
// input register, and its state update and result are formed in a single
// pass from there into the output register. Non-last items never
// wait on the output side; a last item waits only while an earlier result is
// still unclaimed. Degree 0 acts as 1 and degrees above 32 act as 32;
// generator bits at or above the degree are ignored. Write configuration
// only while the unit is idle; all message state clears after each result.
module crc_and_byte_checksum_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [cbcu_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [cbcu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_bit_in,
    input  logic                                i_last,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cbcu_pkg::MAX_DEGREE-1:0]     o_crc_remainder,
    output logic [cbcu_pkg::CHECKSUM_BITS-1:0]  o_checksum_byte,
    output logic                                o_crc_error,
    output logic                                o_checksum_error
);
    import cbcu_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_result;

    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_valid;
    logic    w_out_free;
    logic    w_fire;
    t_result w_result;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.generator_low <= MAX_DEGREE'(7);
            r_cfg.crc_degree    <= DEG_W'(8);
            r_cfg.mode          <= MODE_GENERATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GENERATOR_LOW: r_cfg.generator_low <= i_cfg_data[MAX_DEGREE-1:0];
                CFG_CRC_DEGREE:    r_cfg.crc_degree    <= i_cfg_data[DEG_W-1:0];
                CFG_MODE:          r_cfg.mode          <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign w_in_item.bit_in = i_bit_in;
    assign w_in_item.last   = i_last;

    // the output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // advance the registered item unless it is a last item facing a full output
    assign w_fire     = w_s1_valid && (!w_s1_item.last || w_out_free);

    cbcu_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_fire),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    cbcu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fire   (w_fire),
        .i_item   (w_s1_item),
        .o_result (w_result)
    );

    // result register: load on a last item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_s1_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_s1_item.last) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_crc_remainder  = r_result.crc_remainder;
    assign o_checksum_byte  = r_result.checksum_byte;
    assign o_crc_error      = r_result.crc_error;
    assign o_checksum_error = r_result.checksum_error;

endmodule

FILE: hdl/cbcu_in_stage.sv
// Input register stage of the CRC and byte checksum unit.
// Depends on cbcu_pkg for the item type.
module cbcu_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cbcu_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output cbcu_pkg::t_item o_item
);
    import cbcu_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/cbcu_core.sv
// CRC shift register, mod-255 residue and checksum hold-back state.
// Depends on cbcu_pkg for configuration, item and result types.
module cbcu_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbcu_pkg::t_cfg    i_cfg,
    input  logic              i_fire,
    input  cbcu_pkg::t_item   i_item,
    output cbcu_pkg::t_result o_result
);
    import cbcu_pkg::*;

    logic [MAX_DEGREE-1:0]    r_crc;
    logic [CHECKSUM_BITS-1:0] r_residue;
    logic                     r_nonzero;
    logic [CHECKSUM_BITS-1:0] r_hb_bits;
    logic [HB_COUNT_W-1:0]    r_hb_count;

    logic [MAX_DEGREE-1:0]    n_crc;
    logic [CHECKSUM_BITS-1:0] n_residue;
    logic                     n_nonzero;
    logic [CHECKSUM_BITS-1:0] n_hb_bits;
    logic [HB_COUNT_W-1:0]    n_hb_count;

    logic [DEG_W-1:0]         w_deg;
    logic [DEG_IDX_W-1:0]     w_top_idx;
    logic [MAX_DEGREE:0]      w_full_mask;
    logic [MAX_DEGREE-1:0]    w_mask;
    logic [MAX_DEGREE-1:0]    w_gen;
    logic [MAX_DEGREE-1:0]    w_reg;
    logic                     w_top;
    logic                     w_feed_en;
    logic                     w_feed_bit;
    logic [CHECKSUM_BITS:0]   w_res_sum;
    logic [CHECKSUM_BITS-1:0] w_sum;
    logic [CHECKSUM_BITS-1:0] w_computed;
    logic                     w_check;

    // Clamp the degree into 1..MAX_DEGREE
    always_comb begin
        w_deg = i_cfg.crc_degree;
        if (i_cfg.crc_degree == '0) begin
            w_deg = DEG_W'(1);
        end else if (i_cfg.crc_degree > DEG_W'(MAX_DEGREE)) begin
            w_deg = DEG_W'(MAX_DEGREE);
        end
    end

    assign w_top_idx   = DEG_IDX_W'(w_deg - DEG_W'(1));
    assign w_full_mask = ({{MAX_DEGREE{1'b0}}, 1'b1} << w_deg) - {{MAX_DEGREE{1'b0}}, 1'b1};
    assign w_mask      = w_full_mask[MAX_DEGREE-1:0];
    assign w_gen       = i_cfg.generator_low & w_mask;
    assign w_reg       = r_crc & w_mask;
    assign w_top       = w_reg[w_top_idx];
    assign w_check     = (i_cfg.mode == MODE_CHECK);

    always_comb begin
        n_hb_bits  = r_hb_bits;
        n_hb_count = r_hb_count;
        w_feed_en  = 1'b1;
        w_feed_bit = i_item.bit_in;
        if (w_check) begin
            // divide the whole codeword; delay the data bits by the checksum width
            n_crc = ((w_reg << 1) | {{(MAX_DEGREE-1){1'b0}}, i_item.bit_in}) & w_mask;
            if (w_top) begin
                n_crc = n_crc ^ w_gen;
            end
            if (r_hb_count >= HB_COUNT_W'(CHECKSUM_BITS)) begin
                w_feed_bit = r_hb_bits[CHECKSUM_BITS-1];
            end else begin
                w_feed_en  = 1'b0;
                n_hb_count = r_hb_count + HB_COUNT_W'(1);
            end
            n_hb_bits = {r_hb_bits[CHECKSUM_BITS-2:0], i_item.bit_in};
        end else begin
            n_crc = (w_reg << 1) & w_mask;
            if (w_top ^ i_item.bit_in) begin
                n_crc = n_crc ^ w_gen;
            end
        end

        // residue = 2 * residue + bit, reduced mod 255
        w_res_sum = {r_residue, w_feed_bit};
        if (w_res_sum >= (CHECKSUM_BITS+1)'(255)) begin
            w_res_sum = w_res_sum - (CHECKSUM_BITS+1)'(255);
        end
        if (w_feed_en) begin
            n_residue = w_res_sum[CHECKSUM_BITS-1:0];
            n_nonzero = r_nonzero | w_feed_bit;
        end else begin
            n_residue = r_residue;
            n_nonzero = r_nonzero;
        end
    end

    always_comb begin
        if (!n_nonzero) begin
            w_sum = '0;
        end else if (n_residue == '0) begin
            w_sum = '1;
        end else begin
            w_sum = n_residue;
        end
        w_computed = ~w_sum;
        o_result.crc_remainder  = n_crc;
        o_result.checksum_byte  = w_computed;
        o_result.crc_error      = w_check && (n_crc != '0);
        o_result.checksum_error = w_check && (n_hb_bits != w_computed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= '0;
            r_residue  <= '0;
            r_nonzero  <= 1'b0;
            r_hb_bits  <= '0;
            r_hb_count <= '0;
        end else if (i_fire) begin
            if (i_item.last) begin
                r_crc      <= '0;
                r_residue  <= '0;
                r_nonzero  <= 1'b0;
                r_hb_bits  <= '0;
                r_hb_count <= '0;
            end else begin
                r_crc      <= n_crc;
                r_residue  <= n_residue;
                r_nonzero  <= n_nonzero;
                r_hb_bits  <= n_hb_bits;
                r_hb_count <= n_hb_count;
            end
        end
    end

endmodule
